// ----- rtl/core/mocc_pkg.sv -----
package mocc_pkg;

    // data and register widths
    localparam int PIX_W      = 8;
    localparam int CFG_DIM_W  = 11;
    localparam int CFG_ITER_W = 2;
    localparam int CFG_AW     = 4;
    localparam int APB_DW     = 32;
    localparam int DIM_LIM_W  = 13;

    // default size limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_ITER   = 2;

    // queue depth on both sides of the stage chain
    localparam int QUEUE_DEPTH = 4;

    // register reset values
    localparam logic [CFG_DIM_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_DIM_W-1:0]  RST_FRAME_HEIGHT = 11'd480;
    localparam logic [CFG_ITER_W-1:0] RST_OPEN_ITER    = 2'd1;
    localparam logic [CFG_ITER_W-1:0] RST_CLOSE_ITER   = 2'd1;

    // register indexes
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_OPEN_ITER    = 2'd2;
    localparam logic [1:0] REG_CLOSE_ITER   = 2'd3;

    // input action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // token moving along the stage chain
    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_PIX   = 2'd1,
        K_FLUSH = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [PIX_W-1:0]  pix;
        logic              last;
    } t_tok;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel_in;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } t_out;

    typedef struct packed {
        logic [CFG_DIM_W-1:0]  frame_width;
        logic [CFG_DIM_W-1:0]  frame_height;
        logic [CFG_ITER_W-1:0] open_iter;
        logic [CFG_ITER_W-1:0] close_iter;
    } t_cfg;

    // clamp a size register to 1..lim and return it minus one
    function automatic logic [DIM_LIM_W-1:0] f_clamp_m1(
        input logic [CFG_DIM_W-1:0] v,
        input logic [DIM_LIM_W-1:0] lim
    );
        logic [DIM_LIM_W-1:0] ve;
        ve = {{(DIM_LIM_W-CFG_DIM_W){1'b0}}, v};
        if (v == '0) begin
            return '0;
        end else if (ve > lim) begin
            return lim - DIM_LIM_W'(1);
        end else begin
            return ve - DIM_LIM_W'(1);
        end
    endfunction

endpackage

// ----- rtl/core/mocc_ram.sv -----
module mocc_ram #(
    parameter int P_WIDTH = 16,
    parameter int P_DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);
    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/mocc_fifo.sv -----
module mocc_fifo #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [P_WIDTH-1:0] i_data,
    input  logic               i_pop,
    output logic [P_WIDTH-1:0] o_data,
    output logic               o_empty,
    output logic               o_full
);
    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int NW = $clog2(P_DEPTH + 1);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [AW-1:0]      r_wp, r_rp;
    logic [NW-1:0]      r_cnt;
    logic               push, pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == NW'(P_DEPTH));
    assign push    = i_push && !o_full;
    assign pop     = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(P_DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(P_DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ----- rtl/core/mocc_front.sv -----
module mocc_front #(
    parameter int P_MAX_WIDTH  = 1024,
    parameter int P_MAX_HEIGHT = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  mocc_pkg::t_in                   i_in_word,
    output logic                            o_in_ready,
    input  logic                            i_q_full,
    output logic                            o_push,
    output mocc_pkg::t_tok                  o_tok,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mocc_pkg::CFG_AW-1:0]     paddr,
    input  logic [mocc_pkg::APB_DW-1:0]     pwdata,
    output logic [mocc_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    output mocc_pkg::t_cfg                  o_cfg
);
    import mocc_pkg::*;

    localparam int CW = $clog2(P_MAX_WIDTH);
    localparam int RW = $clog2(P_MAX_HEIGHT);

    t_cfg                 r_cfg;
    logic [CW-1:0]        r_wm1, r_ic, wm1;
    logic [RW-1:0]        r_hm1, r_ir, hm1;
    logic [DIM_LIM_W-1:0] cw_m1, ch_m1;
    logic                 accept, at_start, is_last;

    // register file
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= RST_FRAME_WIDTH;
            r_cfg.frame_height <= RST_FRAME_HEIGHT;
            r_cfg.open_iter    <= RST_OPEN_ITER;
            r_cfg.close_iter   <= RST_CLOSE_ITER;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_FRAME_WIDTH:  r_cfg.frame_width  <= pwdata[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: r_cfg.frame_height <= pwdata[CFG_DIM_W-1:0];
                REG_OPEN_ITER:    r_cfg.open_iter    <= pwdata[CFG_ITER_W-1:0];
                REG_CLOSE_ITER:   r_cfg.close_iter   <= pwdata[CFG_ITER_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_cfg.frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_cfg.frame_height);
            REG_OPEN_ITER:    prdata = APB_DW'(r_cfg.open_iter);
            REG_CLOSE_ITER:   prdata = APB_DW'(r_cfg.close_iter);
        endcase
    end

    assign o_cfg = r_cfg;

    // input raster position, size latched at frame start
    assign cw_m1    = f_clamp_m1(r_cfg.frame_width, DIM_LIM_W'(P_MAX_WIDTH));
    assign ch_m1    = f_clamp_m1(r_cfg.frame_height, DIM_LIM_W'(P_MAX_HEIGHT));
    assign at_start = (r_ic == '0) && (r_ir == '0);
    assign wm1      = at_start ? cw_m1[CW-1:0] : r_wm1;
    assign hm1      = at_start ? ch_m1[RW-1:0] : r_hm1;
    assign is_last  = (r_ic == wm1) && (r_ir == hm1);

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic  <= '0;
            r_ir  <= '0;
            r_wm1 <= '0;
            r_hm1 <= '0;
        end else if (accept && (i_in_word.action == ACT_PIXEL)) begin
            r_wm1 <= wm1;
            r_hm1 <= hm1;
            if (is_last) begin
                r_ic <= '0;
                r_ir <= '0;
            end else if (r_ic == wm1) begin
                r_ic <= '0;
                r_ir <= r_ir + RW'(1);
            end else begin
                r_ic <= r_ic + CW'(1);
            end
        end
    end

    // classify the word into a chain token
    always_comb begin
        o_push     = accept;
        o_tok.pix  = i_in_word.pixel_in;
        if (i_in_word.action == ACT_FLUSH) begin
            o_tok.kind = K_FLUSH;
            o_tok.last = 1'b0;
        end else begin
            o_tok.kind = K_PIX;
            o_tok.last = is_last;
        end
    end
endmodule

// ----- rtl/core/mocc_stage.sv -----
module mocc_stage #(
    parameter int   P_MAX_WIDTH  = 1024,
    parameter int   P_MAX_HEIGHT = 1024,
    parameter logic P_TAKE_MAX   = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_active,
    input  mocc_pkg::t_cfg  i_cfg,
    input  mocc_pkg::t_tok  i_tok,
    output mocc_pkg::t_tok  o_tok
);
    import mocc_pkg::*;

    localparam int CW = $clog2(P_MAX_WIDTH);
    localparam int RW = $clog2(P_MAX_HEIGHT);
    localparam int LW = 2 * PIX_W;

    typedef struct packed {
        logic             active;
        t_tok             tok;
        logic             emit;
        logic             access;
        logic [CW-1:0]    addr;
        logic [PIX_W-1:0] bot;
        logic             top_ok;
        logic             bot_ok;
        logic             left_ok;
        logic             right_ok;
        logic             last;
        logic             first_h1;
        logic [PIX_W-1:0] pix0;
    } t_bstg;

    typedef logic [PIX_W-1:0] t_col [3];

    // frame tracking state
    logic             r_pos_nz, r_in_done, r_out_done;
    logic [CW-1:0]    r_wm1, r_ic, r_qc;
    logic [RW-1:0]    r_hm1, r_ir, r_qr;
    logic [PIX_W-1:0] r_pix0;

    logic                 is_pix, is_fl, restart, emit, emit_pix, emit_fl, q_last;
    logic [CW-1:0]        wm1, ic, qc, qc_inc, addr;
    logic [RW-1:0]        hm1, ir, qr;
    logic [DIM_LIM_W-1:0] cw_m1, ch_m1;

    t_bstg r_b, n_b;

    // window and line buffer side
    t_col             r_win [3];
    t_col             n_win [3];
    t_col             right_old;
    logic [LW-1:0]    rd, line, wdata, r_prev_wdata;
    logic             r_prev_wr, fwd;
    logic [CW-1:0]    r_prev_addr;
    logic [PIX_W-1:0] top, mid, res;
    logic             ok;
    t_tok             n_out, r_out;

    // front half: classify the token against the frame position
    assign cw_m1 = f_clamp_m1(i_cfg.frame_width, DIM_LIM_W'(P_MAX_WIDTH));
    assign ch_m1 = f_clamp_m1(i_cfg.frame_height, DIM_LIM_W'(P_MAX_HEIGHT));

    always_comb begin
        is_pix   = i_active && (i_tok.kind == K_PIX);
        is_fl    = i_active && (i_tok.kind == K_FLUSH);
        restart  = is_pix && (!r_pos_nz || r_in_done);
        wm1      = restart ? cw_m1[CW-1:0] : r_wm1;
        hm1      = restart ? ch_m1[RW-1:0] : r_hm1;
        ic       = restart ? '0 : r_ic;
        ir       = restart ? '0 : r_ir;
        qc       = restart ? '0 : r_qc;
        qr       = restart ? '0 : r_qr;
        emit_pix = is_pix && ((ir >= RW'(2)) || ((ir == RW'(1)) && (ic != '0)));
        emit_fl  = is_fl && r_pos_nz && r_in_done && !r_out_done;
        emit     = emit_pix || emit_fl;
        q_last   = (qc == wm1) && (qr == hm1);
        qc_inc   = (qc == wm1) ? '0 : qc + CW'(1);
        addr     = is_pix ? ic : qc_inc;

        n_b.active   = i_active;
        n_b.tok      = i_tok;
        n_b.emit     = emit;
        n_b.access   = is_pix || emit_fl;
        n_b.addr     = addr;
        n_b.bot      = is_pix ? i_tok.pix : '0;
        n_b.top_ok   = (qr != '0);
        n_b.bot_ok   = (qr != hm1);
        n_b.left_ok  = (qc != '0);
        n_b.right_ok = (qc != wm1);
        n_b.last     = q_last;
        n_b.first_h1 = emit_fl && (qc == '0) && (qr == '0);
        n_b.pix0     = r_pix0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_nz   <= 1'b0;
            r_in_done  <= 1'b0;
            r_out_done <= 1'b0;
            r_wm1      <= '0;
            r_hm1      <= '0;
            r_ic       <= '0;
            r_ir       <= '0;
            r_qc       <= '0;
            r_qr       <= '0;
            r_b        <= '0;
        end else if (i_en) begin
            r_b <= n_b;
            if (!i_active) begin
                r_pos_nz <= 1'b0;
            end else begin
                if (is_pix) begin
                    r_wm1     <= wm1;
                    r_hm1     <= hm1;
                    r_pos_nz  <= 1'b1;
                    r_in_done <= (ic == wm1) && (ir == hm1);
                    if (ic == wm1) begin
                        r_ic <= '0;
                        r_ir <= ir + RW'(1);
                    end else begin
                        r_ic <= ic + CW'(1);
                        r_ir <= ir;
                    end
                end
                if (restart) begin
                    r_qc       <= '0;
                    r_qr       <= '0;
                    r_out_done <= 1'b0;
                end
                if (emit) begin
                    r_qc       <= qc_inc;
                    r_qr       <= (qc == wm1) ? qr + RW'(1) : qr;
                    r_out_done <= q_last;
                end
            end
        end
    end

    // first pixel of the frame, needed when the frame is a single row
    always_ff @(posedge i_clk) begin
        if (i_en && is_pix && (ic == '0) && (ir == '0)) begin
            r_pix0 <= i_tok.pix;
        end
    end

    // two line delays share one word: upper byte two rows back, lower one row back
    mocc_ram #(
        .P_WIDTH (LW),
        .P_DEPTH (P_MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_en && r_b.access),
        .i_waddr (r_b.addr),
        .i_wdata (wdata),
        .i_re    (i_en && n_b.access),
        .i_raddr (addr),
        .o_rdata (rd)
    );

    // back half: forward the previous write, shift the window, reduce
    always_comb begin
        fwd   = r_prev_wr && (r_prev_addr == r_b.addr);
        line  = fwd ? r_prev_wdata : rd;
        top   = line[LW-1:PIX_W];
        mid   = line[PIX_W-1:0];
        wdata = {mid, r_b.bot};

        right_old = r_win[2];
        if (r_b.first_h1) begin
            right_old[1] = r_b.pix0;
        end

        n_win = r_win;
        if (r_b.access) begin
            n_win[0]    = r_win[1];
            n_win[1]    = right_old;
            n_win[2][0] = top;
            n_win[2][1] = mid;
            n_win[2][2] = r_b.bot;
        end

        res = P_TAKE_MAX ? '0 : PIX_MAX;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                ok = ((r != 0) || r_b.top_ok) && ((r != 2) || r_b.bot_ok) &&
                     ((c != 0) || r_b.left_ok) && ((c != 2) || r_b.right_ok);
                if (!ok) begin
                    if (!P_TAKE_MAX) begin
                        res = '0;
                    end
                end else if (P_TAKE_MAX ? (n_win[c][r] > res) : (n_win[c][r] < res)) begin
                    res = n_win[c][r];
                end
            end
        end

        if (!r_b.active) begin
            n_out = r_b.tok;
        end else if (r_b.emit) begin
            n_out.kind = K_PIX;
            n_out.pix  = res;
            n_out.last = r_b.last;
        end else begin
            n_out.kind = (r_b.tok.kind == K_NONE) ? K_NONE : K_FLUSH;
            n_out.pix  = '0;
            n_out.last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_wr <= 1'b0;
            r_out     <= '0;
        end else if (i_en) begin
            r_prev_wr <= r_b.access;
            r_out     <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_win        <= n_win;
            r_prev_addr  <= r_b.addr;
            r_prev_wdata <= wdata;
        end
    end

    assign o_tok = r_out;
endmodule

// ----- rtl/core/morphology_open_close_3x3.sv -----
// channel | direction | handshake                 | word
// input   | in        | i_in_valid / o_in_ready   | i_in_word  (action, pixel_in)
// output  | out       | o_out_valid / i_out_ready | o_out_word (pixel_out, frame_last)
// config  | in        | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// one word a cycle in while the input queue has room, and out while the receiver
// is ready; each of the 4*P_MAX_ITER stages registers the token for the line buffer
// read, then registers the window min/max. the line buffers need no clearing:
// synchronous active-low reset clears only the control state. a stalled output
// freezes the whole chain once the output queue fills; the input side keeps
// taking words until the input queue fills.
module morphology_open_close_3x3 #(
    parameter int P_MAX_WIDTH  = mocc_pkg::MAX_WIDTH,
    parameter int P_MAX_HEIGHT = mocc_pkg::MAX_HEIGHT,
    parameter int P_MAX_ITER   = mocc_pkg::MAX_ITER
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  mocc_pkg::t_in                i_in_word,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    output mocc_pkg::t_out               o_out_word,
    input  logic                         i_out_ready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mocc_pkg::CFG_AW-1:0]  paddr,
    input  logic [mocc_pkg::APB_DW-1:0]  pwdata,
    output logic [mocc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import mocc_pkg::*;

    localparam int NST = 4 * P_MAX_ITER;
    localparam int TW  = $bits(t_tok);
    localparam int OW  = $bits(t_out);

    t_cfg          cfg;
    t_tok          f_tok, q_tok;
    logic [TW-1:0] q_data;
    logic          f_push, q_full, q_empty, q_pop;
    t_tok          w_tok [NST+1];
    logic          en, o_full, o_empty;
    logic [OW-1:0] o_data;
    t_out          o_word;
    logic [3:0]    nopen, nclose;

    // front: registers, raster position, word classification
    mocc_front #(
        .P_MAX_WIDTH  (P_MAX_WIDTH),
        .P_MAX_HEIGHT (P_MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_ready (o_in_ready),
        .i_q_full   (q_full),
        .o_push     (f_push),
        .o_tok      (f_tok),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_cfg      (cfg)
    );

    // token queue between front and chain
    mocc_fifo #(
        .P_WIDTH (TW),
        .P_DEPTH (QUEUE_DEPTH)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_tok),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // chain advances whenever the output queue has room
    assign en    = !o_full;
    assign q_pop = en && !q_empty;
    assign q_tok = t_tok'(q_data);

    always_comb begin
        w_tok[0] = q_tok;
        if (q_empty) begin
            w_tok[0].kind = K_NONE;
        end
    end

    // effective pass counts
    always_comb begin
        nopen  = ({2'b00, cfg.open_iter} > 4'(P_MAX_ITER)) ?
                 4'(P_MAX_ITER) : {2'b00, cfg.open_iter};
        nclose = ({2'b00, cfg.close_iter} > 4'(P_MAX_ITER)) ?
                 4'(P_MAX_ITER) : {2'b00, cfg.close_iter};
    end

    // erode/dilate stage chain: openings first, closings after
    for (genvar s = 0; s < NST; s++) begin : g_stage
        localparam bit IS_OPEN  = (s < 2 * P_MAX_ITER);
        localparam int T        = IS_OPEN ? s : s - 2 * P_MAX_ITER;
        localparam bit TAKE_MAX = IS_OPEN ? ((T % 2) == 1) : ((T % 2) == 0);
        logic active;

        assign active = IS_OPEN ? (4'(T / 2) < nopen) : (4'(T / 2) < nclose);

        mocc_stage #(
            .P_MAX_WIDTH  (P_MAX_WIDTH),
            .P_MAX_HEIGHT (P_MAX_HEIGHT),
            .P_TAKE_MAX   (TAKE_MAX)
        ) u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_active (active),
            .i_cfg    (cfg),
            .i_tok    (w_tok[s]),
            .o_tok    (w_tok[s+1])
        );
    end

    // result queue
    always_comb begin
        o_word.pixel_out  = w_tok[NST].pix;
        o_word.frame_last = w_tok[NST].last;
    end

    mocc_fifo #(
        .P_WIDTH (OW),
        .P_DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en && (w_tok[NST].kind == K_PIX)),
        .i_data  (o_word),
        .i_pop   (i_out_ready),
        .o_data  (o_data),
        .o_empty (o_empty),
        .o_full  (o_full)
    );

    assign o_out_valid = !o_empty;
    assign o_out_word  = t_out'(o_data);
endmodule

// ----- tb/morphology_open_close_3x3_tb.sv -----
module morphology_open_close_3x3_tb;
    import mocc_pkg::*;

    localparam int NSTG = 4 * MAX_ITER;
    localparam int LBUF = 2 * MAX_WIDTH + 3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    t_in                   i_in_word;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out                  o_out_word;
    logic                  i_out_ready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    morphology_open_close_3x3 DUT (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // predictor state
    logic [PIX_W-1:0] line_mem [NSTG][LBUF];
    int unsigned stg_pos [NSTG];
    int unsigned stg_done [NSTG];
    int unsigned stg_w [NSTG];
    int unsigned stg_h [NSTG];
    int unsigned raster_pos, raster_w, raster_h;
    int unsigned reg_width, reg_height, reg_open, reg_close;

    t_out pending_pix [$];
    int unsigned mismatches, words_in, words_out, frames_sent;
    int tx_idle, rx_idle, hold_cycles;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // 3x3 min or max around raster position q of stage s, zero padded
    function automatic logic [PIX_W-1:0] window_pick(int s, int unsigned q, bit take_max);
        int r, c, nr, nc;
        logic [PIX_W-1:0] acc, v;
        r = q / stg_w[s];
        c = q % stg_w[s];
        acc = take_max ? 8'd0 : PIX_MAX;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                nr = r + dr;
                nc = c + dc;
                if (nr < 0 || nr >= int'(stg_h[s]) || nc < 0 || nc >= int'(stg_w[s])) begin
                    if (!take_max) acc = 8'd0;
                end else begin
                    v = line_mem[s][(nr * stg_w[s] + nc) % LBUF];
                    if (take_max ? (v > acc) : (v < acc)) acc = v;
                end
            end
        end
        return acc;
    endfunction

    // one window stage; returns whether a pixel leaves it
    function automatic bit stage_advance(int s, bit take_max, bit vin,
                                         inout logic [PIX_W-1:0] pix, inout logic last);
        int unsigned total, q;
        total = stg_w[s] * stg_h[s];
        if (vin) begin
            if (stg_pos[s] == 0 || stg_pos[s] >= total) begin
                stg_w[s] = clamp_dim(reg_width, MAX_WIDTH);
                stg_h[s] = clamp_dim(reg_height, MAX_HEIGHT);
                total = stg_w[s] * stg_h[s];
                stg_pos[s] = 0;
                stg_done[s] = 0;
            end
            line_mem[s][stg_pos[s] % LBUF] = pix;
            stg_pos[s]++;
            if (stg_pos[s] <= stg_done[s] + stg_w[s] + 1) return 1'b0;
        end else begin
            if (stg_pos[s] == 0 || stg_pos[s] < total || stg_done[s] >= total) return 1'b0;
        end
        q = stg_done[s];
        pix = window_pick(s, q, take_max);
        last = (q == total - 1);
        stg_done[s]++;
        return 1'b1;
    endfunction

    // run one accepted word through the chain model
    function automatic void filter_word(t_in w);
        bit vld, active, take_max;
        logic [PIX_W-1:0] pix;
        logic last;
        int unsigned nopen, nclose;
        t_out res;
        vld = (w.action == ACT_PIXEL);
        pix = w.pixel_in;
        last = 1'b0;
        nopen = reg_open > MAX_ITER ? MAX_ITER : reg_open;
        nclose = reg_close > MAX_ITER ? MAX_ITER : reg_close;
        if (vld) begin
            if (raster_pos == 0) begin
                raster_w = clamp_dim(reg_width, MAX_WIDTH);
                raster_h = clamp_dim(reg_height, MAX_HEIGHT);
            end
            last = (raster_pos == raster_w * raster_h - 1);
            raster_pos++;
            if (raster_pos >= raster_w * raster_h) raster_pos = 0;
        end
        for (int s = 0; s < NSTG; s++) begin
            if (s < 2 * MAX_ITER) begin
                active = (s / 2) < nopen;
                take_max = (s % 2) == 1;
            end else begin
                active = ((s - 2 * MAX_ITER) / 2) < nclose;
                take_max = ((s - 2 * MAX_ITER) % 2) == 0;
            end
            if (!active) begin
                stg_pos[s] = 0;
                stg_done[s] = 0;
            end else begin
                vld = stage_advance(s, take_max, vld, pix, last);
            end
        end
        if (vld) begin
            res.pixel_out = pix;
            res.frame_last = last;
            pending_pix.push_back(res);
        end
    endfunction

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_out++;
            if (pending_pix.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: pixel %0d last %0b",
                             o_out_word.pixel_out, o_out_word.frame_last);
            end else begin
                want = pending_pix.pop_front();
                if (want.pixel_out !== o_out_word.pixel_out ||
                    want.frame_last !== o_out_word.frame_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pixel exp %0d got %0d, last exp %0b got %0b",
                                 want.pixel_out, o_out_word.pixel_out,
                                 want.frame_last, o_out_word.frame_last);
                end
            end
        end
    end

    // send one word and model it once accepted
    task automatic send_word(logic act, logic [PIX_W-1:0] pix);
        t_in w;
        w.action = act;
        w.pixel_in = pix;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word = w;
        do @(posedge i_clk); while (!o_in_ready);
        filter_word(w);
        words_in++;
    endtask

    // lower valid and wait until every expected word is out
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (pending_pix.size() == 0);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [APB_DW-1:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = CFG_AW'(idx) << 2;
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_FRAME_WIDTH:  reg_width = val[CFG_DIM_W-1:0];
            REG_FRAME_HEIGHT: reg_height = val[CFG_DIM_W-1:0];
            REG_OPEN_ITER:    reg_open = val[CFG_ITER_W-1:0];
            default:          reg_close = val[CFG_ITER_W-1:0];
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_config(int unsigned w, int unsigned h, int unsigned no, int unsigned nc);
        wait_idle();
        reg_write(REG_FRAME_WIDTH, w);
        reg_write(REG_FRAME_HEIGHT, h);
        reg_write(REG_OPEN_ITER, no);
        reg_write(REG_CLOSE_ITER, nc);
    endtask

    // one frame of pixels; style 0 random, 1 extremes, 2 flat
    task automatic send_frame(int style, bit drain);
        int unsigned n, w, nact;
        logic [PIX_W-1:0] p;
        w = clamp_dim(reg_width, MAX_WIDTH);
        n = w * clamp_dim(reg_height, MAX_HEIGHT);
        // each active stage holds back one row plus one pixel
        nact = 2 * ((reg_open > MAX_ITER) ? MAX_ITER : reg_open) +
               2 * ((reg_close > MAX_ITER) ? MAX_ITER : reg_close);
        for (int unsigned k = 0; k < n; k++) begin
            case (style)
                1: p = ($urandom_range(1) != 0) ? PIX_MAX : 8'd0;
                2: p = 8'd200;
                default: p = PIX_W'($urandom);
            endcase
            send_word(ACT_PIXEL, p);
        end
        frames_sent++;
        if (drain && nact != 0)
            for (int unsigned k = 0; k < nact * (w + 1) + 1; k++)
                send_word(ACT_FLUSH, PIX_W'($urandom));
    endtask

    task automatic test_directed();
        tx_idle = 19;
        rx_idle = 46;
        set_config(3, 3, 1, 1);
        send_word(ACT_FLUSH, 8'hAA);            // flush with nothing pending
        send_frame(1, 1'b1);
        send_frame(0, 1'b0);                    // next frame starts before drain
        send_frame(2, 1'b1);
        set_config(4, 2, 0, 0);                 // every stage bypassed
        send_frame(0, 1'b1);
        set_config(0, 0, 3, 3);                 // sizes and counts clamp
        send_frame(1, 1'b1);
        set_config(5, 1, 2, 0);                 // single row
        send_frame(0, 1'b1);
        set_config(1, 4, 0, 2);                 // single column
        send_frame(0, 1'b1);
    endtask

    task automatic test_random();
        int unsigned w, h, cut;
        while (words_in < 1440) begin
            if (words_in < 800) begin
                tx_idle = 46;
                rx_idle = 19;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_config(w, h, $urandom_range(3), $urandom_range(3));
            case ($urandom_range(9))
                0: begin
                    // broken frame: partial, with stray flushes in it
                    cut = $urandom_range(w * h);
                    for (int unsigned k = 0; k < cut; k++) begin
                        send_word(($urandom_range(3) == 0) ? ACT_FLUSH : ACT_PIXEL,
                                  PIX_W'($urandom));
                    end
                    send_frame(0, 1'b1);
                end
                1: begin
                    send_frame(0, 1'b0);
                    send_frame(0, 1'b1);
                end
                default: send_frame(($urandom_range(4) == 0) ? 1 : 0, 1'b1);
            endcase
        end
    endtask

    task automatic test_backpressure();
        tx_idle = 0;
        rx_idle = 0;
        set_config(6, 5, 2, 2);
        @(negedge i_clk);
        hold_cycles = 300;
        send_frame(0, 1'b1);
        // sender pause until all results are back, then another frame
        wait_idle();
        send_frame(0, 1'b1);
    endtask

    // limit
    initial begin
        #6000000;
        $display("[morphology_open_close_3x3] ERROR");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_idle = 0;
        rx_idle = 0;
        hold_cycles = 0;
        mismatches = 0;
        words_in = 0;
        words_out = 0;
        frames_sent = 0;
        raster_pos = 0;
        raster_w = 1;
        raster_h = 1;
        reg_width = RST_FRAME_WIDTH;
        reg_height = RST_FRAME_HEIGHT;
        reg_open = RST_OPEN_ITER;
        reg_close = RST_CLOSE_ITER;
        for (int s = 0; s < NSTG; s++) begin
            stg_pos[s] = 0;
            stg_done[s] = 0;
            stg_w[s] = 0;
            stg_h[s] = 0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random();
        test_backpressure();
        wait_idle();
        repeat (100) @(posedge i_clk);

        $display("covered %0d frames, %0d words in, %0d words out, %0d mismatches",
                 frames_sent, words_in, words_out, mismatches);
        $display("sizes 1x1 to 8x6, single rows and columns, clamped sizes and counts, "
                 + "every open/close count, long output stall");
        if (mismatches == 0 && pending_pix.size() == 0) begin
            $display("[morphology_open_close_3x3] OK");
        end else begin
            $display("[morphology_open_close_3x3] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/mocc_pkg.sv
rtl/core/mocc_ram.sv
rtl/core/mocc_fifo.sv
rtl/core/mocc_front.sv
rtl/core/mocc_stage.sv
rtl/core/morphology_open_close_3x3.sv
tb/morphology_open_close_3x3_tb.sv
